// ----- src/lrab_pkg.sv -----
// Package for the line rasterizer with alpha blending.
// Holds shared constants, configuration and request codes, and helper functions.
// No dependencies.
package lrab_pkg;

    // Default coordinate width and the depth of the front-to-back queue.
    localparam int COORD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    // Fixed port widths.
    localparam int PORT_COORD_W = 16;
    localparam int CFG_W        = 14;
    localparam int CFG_IDX_W    = 1;
    localparam int CHAN_W       = 8;

    localparam logic [CFG_W-1:0]  RESET_WIDTH  = 14'd1920;
    localparam logic [CFG_W-1:0]  RESET_HEIGHT = 14'd1080;
    localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_WIDTH  = 1'b0,
        CFG_TARGET_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_STEP = 1'b1
    } t_req;

    // Width of one queued command for a given coordinate width:
    // type, four coordinates, two deltas, two step signs, error, color, destination.
    function automatic int cmd_bits(input int cb);
        return 1 + 4 * cb + 2 * (cb + 2) + 2 + (cb + 3) + 32 + 24;
    endfunction

    // floor(v / 255), exact for every v below 65280.
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ----- src/lrab_front.sv -----
// Front end of the line rasterizer: accepts requests, wraps coordinates and
// prepares the line setup terms, then pushes commands into the queue.
// Depends on lrab_pkg.
module lrab_front #(
    parameter int COORD_BITS = lrab_pkg::COORD_BITS_DEF,
    parameter int CMD_W      = lrab_pkg::cmd_bits(COORD_BITS)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_req_type,
    input  logic signed [lrab_pkg::PORT_COORD_W-1:0] i_start_x,
    input  logic signed [lrab_pkg::PORT_COORD_W-1:0] i_start_y,
    input  logic signed [lrab_pkg::PORT_COORD_W-1:0] i_end_x,
    input  logic signed [lrab_pkg::PORT_COORD_W-1:0] i_end_y,
    input  logic [lrab_pkg::CHAN_W-1:0]           i_src_blue,
    input  logic [lrab_pkg::CHAN_W-1:0]           i_src_green,
    input  logic [lrab_pkg::CHAN_W-1:0]           i_src_red,
    input  logic [lrab_pkg::CHAN_W-1:0]           i_src_alpha,
    input  logic [lrab_pkg::CHAN_W-1:0]           i_dst_blue,
    input  logic [lrab_pkg::CHAN_W-1:0]           i_dst_green,
    input  logic [lrab_pkg::CHAN_W-1:0]           i_dst_red,
    output logic                                  o_push,
    output logic [CMD_W-1:0]                      o_push_data,
    input  logic                                  i_queue_full
);
    import lrab_pkg::*;

    localparam int CB = COORD_BITS;

    typedef struct packed {
        logic                 is_step;
        logic signed [CB-1:0] x0;
        logic signed [CB-1:0] y0;
        logic signed [CB-1:0] x1;
        logic signed [CB-1:0] y1;
        logic signed [CB+1:0] adx;
        logic signed [CB+1:0] ndy;
        logic                 sx_neg;
        logic                 sy_neg;
        logic signed [CB+2:0] err;
        logic [31:0]          color;
        logic [23:0]          dst;
    } t_cmd;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    t_cmd q_cmd;
    logic accept;

    logic signed [CB-1:0] x0, y0, x1, y1;
    logic signed [CB+1:0] x0e, y0e, x1e, y1e;
    logic                 x_lt, y_lt;

    assign o_push     = r_valid && !i_queue_full;
    assign o_in_stall = r_valid && i_queue_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        x0   = CB'(i_start_x);
        y0   = CB'(i_start_y);
        x1   = CB'(i_end_x);
        y1   = CB'(i_end_y);
        x0e  = (CB+2)'(x0);
        y0e  = (CB+2)'(y0);
        x1e  = (CB+2)'(x1);
        y1e  = (CB+2)'(y1);
        x_lt = x0 < x1;
        y_lt = y0 < y1;

        n_cmd         = '0;
        n_cmd.is_step = (t_req'(i_req_type) == REQ_STEP);
        n_cmd.x0      = x0;
        n_cmd.y0      = y0;
        n_cmd.x1      = x1;
        n_cmd.y1      = y1;
        // Absolute x delta and negated absolute y delta, each picked from two subtracts by the endpoint comparison.
        n_cmd.adx     = x_lt ? (x1e - x0e) : (x0e - x1e);
        n_cmd.ndy     = y_lt ? (y0e - y1e) : (y1e - y0e);
        n_cmd.sx_neg  = !x_lt;
        n_cmd.sy_neg  = !y_lt;
        n_cmd.color   = {i_src_alpha, i_src_red, i_src_green, i_src_blue};
        n_cmd.dst     = {i_dst_red, i_dst_green, i_dst_blue};
    end

    // The initial error term is added on the way into the queue.
    always_comb begin
        q_cmd     = r_cmd;
        q_cmd.err = (CB+3)'(r_cmd.adx) + (CB+3)'(r_cmd.ndy);
    end

    assign o_push_data = q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- src/lrab_queue.sv -----
// Short command queue between the front and back ends of the line rasterizer.
// Depends on lrab_pkg for its default depth.
module lrab_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = lrab_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_not_empty,
    output logic [DATA_W-1:0] o_pop_data
);
    import lrab_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- src/lrab_back.sv -----
// Back end of the line rasterizer: Bresenham walker state, blend multiply stage
// and the registered result stage.
// Depends on lrab_pkg.
module lrab_back #(
    parameter int COORD_BITS = lrab_pkg::COORD_BITS_DEF,
    parameter int CMD_W      = lrab_pkg::cmd_bits(COORD_BITS)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [lrab_pkg::CFG_W-1:0]             i_target_width,
    input  logic [lrab_pkg::CFG_W-1:0]             i_target_height,
    input  logic                                   i_cmd_valid,
    input  logic [CMD_W-1:0]                       i_cmd_data,
    output logic                                   o_cmd_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [lrab_pkg::PORT_COORD_W-1:0] o_write_x,
    output logic signed [lrab_pkg::PORT_COORD_W-1:0] o_write_y,
    output logic                                   o_write_enable,
    output logic [lrab_pkg::CHAN_W-1:0]            o_out_blue,
    output logic [lrab_pkg::CHAN_W-1:0]            o_out_green,
    output logic [lrab_pkg::CHAN_W-1:0]            o_out_red,
    output logic signed [lrab_pkg::PORT_COORD_W-1:0] o_next_x,
    output logic signed [lrab_pkg::PORT_COORD_W-1:0] o_next_y,
    output logic                                   o_line_done
);
    import lrab_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int CMP_W = ((CB > CFG_W + 1) ? CB : CFG_W + 1) + 1;

    typedef struct packed {
        logic                 is_step;
        logic signed [CB-1:0] x0;
        logic signed [CB-1:0] y0;
        logic signed [CB-1:0] x1;
        logic signed [CB-1:0] y1;
        logic signed [CB+1:0] adx;
        logic signed [CB+1:0] ndy;
        logic                 sx_neg;
        logic                 sy_neg;
        logic signed [CB+2:0] err;
        logic [31:0]          color;
        logic [23:0]          dst;
    } t_cmd;

    t_cmd cmd;
    assign cmd = i_cmd_data;

    // Walker state.
    logic signed [CB-1:0] r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic signed [CB-1:0] n_cur_x, n_cur_y, n_goal_x, n_goal_y;
    logic signed [CB+1:0] r_adx, r_ndy, n_adx, n_ndy;
    logic                 r_sx_neg, r_sy_neg, n_sx_neg, n_sy_neg;
    logic signed [CB+2:0] r_err, n_err;
    logic [31:0]          r_color, n_color;
    logic                 r_active, n_active;

    // Multiply stage.
    logic                 r_s1_valid;
    logic signed [CB-1:0] r_s1_wx, r_s1_wy, r_s1_nx, r_s1_ny;
    logic                 r_s1_we, r_s1_done;
    logic [15:0]          r_s1_sum_b, r_s1_sum_g, r_s1_sum_r;
    logic signed [CB-1:0] n_s1_wx, n_s1_wy;
    logic                 n_s1_we, n_s1_done;
    logic [15:0]          n_s1_sum_b, n_s1_sum_g, n_s1_sum_r;

    // Result stage.
    logic r_o_valid;

    logic out_ready, s1_ready, s1_move;
    logic signed [CB+3:0] e2, adx_e, ndy_e;
    logic signed [CB+2:0] add_x, add_y;
    logic                 go_x, go_y, in_target, at_goal;
    logic [CHAN_W-1:0]    alpha, inv_alpha;

    assign out_ready = !r_o_valid || !i_out_stall;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign s1_move   = r_s1_valid && out_ready;
    assign o_cmd_pop = i_cmd_valid && s1_ready;
    assign o_out_valid = r_o_valid;

    always_comb begin
        alpha     = r_color[31:24];
        inv_alpha = CHAN_MAX - alpha;
        in_target = !r_cur_x[CB-1] && !r_cur_y[CB-1]
                    && (CMP_W'(r_cur_x[CB-2:0]) < CMP_W'(i_target_width))
                    && (CMP_W'(r_cur_y[CB-2:0]) < CMP_W'(i_target_height))
                    && (alpha != '0);
        at_goal   = (r_cur_x == r_goal_x) && (r_cur_y == r_goal_y);
        e2        = $signed({r_err, 1'b0});
        adx_e     = (CB+4)'(r_adx);
        ndy_e     = (CB+4)'(r_ndy);
        go_x      = (e2 >= ndy_e);
        go_y      = (e2 <= adx_e);
        add_x     = go_x ? (CB+3)'(r_ndy) : '0;
        add_y     = go_y ? (CB+3)'(r_adx) : '0;

        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_goal_x = r_goal_x;
        n_goal_y = r_goal_y;
        n_adx    = r_adx;
        n_ndy    = r_ndy;
        n_sx_neg = r_sx_neg;
        n_sy_neg = r_sy_neg;
        n_err    = r_err;
        n_color  = r_color;
        n_active = r_active;

        n_s1_wx    = '0;
        n_s1_wy    = '0;
        n_s1_we    = 1'b0;
        n_s1_done  = 1'b0;
        n_s1_sum_b = '0;
        n_s1_sum_g = '0;
        n_s1_sum_r = '0;

        if (!cmd.is_step) begin
            // A load drops any line in progress.
            n_cur_x  = cmd.x0;
            n_cur_y  = cmd.y0;
            n_goal_x = cmd.x1;
            n_goal_y = cmd.y1;
            n_adx    = cmd.adx;
            n_ndy    = cmd.ndy;
            n_sx_neg = cmd.sx_neg;
            n_sy_neg = cmd.sy_neg;
            n_err    = cmd.err;
            n_color  = cmd.color;
            n_active = 1'b1;
        end else if (!r_active) begin
            n_s1_wx   = r_cur_x;
            n_s1_wy   = r_cur_y;
            n_s1_done = 1'b1;
        end else begin
            n_s1_wx = r_cur_x;
            n_s1_wy = r_cur_y;
            n_s1_we = in_target;
            if (in_target) begin
                n_s1_sum_b = 16'(r_color[7:0]) * 16'(alpha)
                             + 16'(cmd.dst[7:0]) * 16'(inv_alpha);
                n_s1_sum_g = 16'(r_color[15:8]) * 16'(alpha)
                             + 16'(cmd.dst[15:8]) * 16'(inv_alpha);
                n_s1_sum_r = 16'(r_color[23:16]) * 16'(alpha)
                             + 16'(cmd.dst[23:16]) * 16'(inv_alpha);
            end
            if (at_goal) begin
                n_active  = 1'b0;
                n_s1_done = 1'b1;
            end else begin
                n_err = r_err + add_x + add_y;
                if (go_x) begin
                    n_cur_x = r_sx_neg ? r_cur_x - CB'(1) : r_cur_x + CB'(1);
                end
                if (go_y) begin
                    n_cur_y = r_sy_neg ? r_cur_y - CB'(1) : r_cur_y + CB'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_goal_x   <= '0;
            r_goal_y   <= '0;
            r_adx      <= '0;
            r_ndy      <= '0;
            r_sx_neg   <= 1'b0;
            r_sy_neg   <= 1'b0;
            r_err      <= '0;
            r_color    <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_active <= n_active;
                r_cur_x  <= n_cur_x;
                r_cur_y  <= n_cur_y;
                r_goal_x <= n_goal_x;
                r_goal_y <= n_goal_y;
                r_adx    <= n_adx;
                r_ndy    <= n_ndy;
                r_sx_neg <= n_sx_neg;
                r_sy_neg <= n_sy_neg;
                r_err    <= n_err;
                r_color  <= n_color;
            end
            if (s1_ready) begin
                r_s1_valid <= o_cmd_pop;
            end
            if (out_ready) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1_wx    <= n_s1_wx;
            r_s1_wy    <= n_s1_wy;
            r_s1_we    <= n_s1_we;
            r_s1_done  <= n_s1_done;
            r_s1_sum_b <= n_s1_sum_b;
            r_s1_sum_g <= n_s1_sum_g;
            r_s1_sum_r <= n_s1_sum_r;
            r_s1_nx    <= n_cur_x;
            r_s1_ny    <= n_cur_y;
        end
        if (s1_move) begin
            o_write_x      <= PORT_COORD_W'(r_s1_wx);
            o_write_y      <= PORT_COORD_W'(r_s1_wy);
            o_write_enable <= r_s1_we;
            o_out_blue     <= div255(r_s1_sum_b);
            o_out_green    <= div255(r_s1_sum_g);
            o_out_red      <= div255(r_s1_sum_r);
            o_next_x       <= PORT_COORD_W'(r_s1_nx);
            o_next_y       <= PORT_COORD_W'(r_s1_ny);
            o_line_done    <= r_s1_done;
        end
    end

endmodule

// ----- src/line_rasterizer_alpha_blend.sv -----
// Channel   | Direction | Handshake                  | Contents
// input     | in        | i_in_valid / o_in_stall    | request type, endpoints, colors
// result    | out       | o_out_valid / i_out_stall  | blended point, next point, done
// config    | in        | i_cfg_valid / o_cfg_ready  | register index, 14-bit value
//
// One request is taken per cycle when the queue has room; a request's result
// passes through the front register, the queue, the multiply stage and the
// result register, with a sustained rate of one result per clock while the
// output is not stalled. Reset is synchronous and active low; it empties
// the queue, clears the pipeline and leaves no line active. A stalled output
// backs up through the pipeline and the four-entry queue before o_in_stall rises.
module line_rasterizer_alpha_blend #(
    parameter int COORD_BITS = lrab_pkg::COORD_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_req_type,
    input  logic signed [lrab_pkg::PORT_COORD_W-1:0]  i_start_x,
    input  logic signed [lrab_pkg::PORT_COORD_W-1:0]  i_start_y,
    input  logic signed [lrab_pkg::PORT_COORD_W-1:0]  i_end_x,
    input  logic signed [lrab_pkg::PORT_COORD_W-1:0]  i_end_y,
    input  logic [lrab_pkg::CHAN_W-1:0]             i_src_blue,
    input  logic [lrab_pkg::CHAN_W-1:0]             i_src_green,
    input  logic [lrab_pkg::CHAN_W-1:0]             i_src_red,
    input  logic [lrab_pkg::CHAN_W-1:0]             i_src_alpha,
    input  logic [lrab_pkg::CHAN_W-1:0]             i_dst_blue,
    input  logic [lrab_pkg::CHAN_W-1:0]             i_dst_green,
    input  logic [lrab_pkg::CHAN_W-1:0]             i_dst_red,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [lrab_pkg::PORT_COORD_W-1:0]  o_write_x,
    output logic signed [lrab_pkg::PORT_COORD_W-1:0]  o_write_y,
    output logic                                    o_write_enable,
    output logic [lrab_pkg::CHAN_W-1:0]             o_out_blue,
    output logic [lrab_pkg::CHAN_W-1:0]             o_out_green,
    output logic [lrab_pkg::CHAN_W-1:0]             o_out_red,
    output logic signed [lrab_pkg::PORT_COORD_W-1:0]  o_next_x,
    output logic signed [lrab_pkg::PORT_COORD_W-1:0]  o_next_y,
    output logic                                    o_line_done,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [lrab_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [lrab_pkg::CFG_W-1:0]              i_cfg_data
);
    import lrab_pkg::*;

    localparam int CMD_W = cmd_bits(COORD_BITS);

    logic [CFG_W-1:0] r_target_width;
    logic [CFG_W-1:0] r_target_height;

    logic             push, queue_full, pop, queue_not_empty;
    logic [CMD_W-1:0] push_data, pop_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_width  <= RESET_WIDTH;
            r_target_height <= RESET_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_WIDTH:  r_target_width  <= i_cfg_data;
                CFG_TARGET_HEIGHT: r_target_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lrab_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_src_blue   (i_src_blue),
        .i_src_green  (i_src_green),
        .i_src_red    (i_src_red),
        .i_src_alpha  (i_src_alpha),
        .i_dst_blue   (i_dst_blue),
        .i_dst_green  (i_dst_green),
        .i_dst_red    (i_dst_red),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_queue_full (queue_full)
    );

    lrab_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_not_empty (queue_not_empty),
        .o_pop_data  (pop_data)
    );

    lrab_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_target_width  (r_target_width),
        .i_target_height (r_target_height),
        .i_cmd_valid     (queue_not_empty),
        .i_cmd_data      (pop_data),
        .o_cmd_pop       (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_x       (o_write_x),
        .o_write_y       (o_write_y),
        .o_write_enable  (o_write_enable),
        .o_out_blue      (o_out_blue),
        .o_out_green     (o_out_green),
        .o_out_red       (o_out_red),
        .o_next_x        (o_next_x),
        .o_next_y        (o_next_y),
        .o_line_done     (o_line_done)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for line_rasterizer_alpha_blend: a queue-fed driver, a monitor and
// a Bresenham walk / alpha blend predictor that scores every pixel result in order.
// Depends on lrab_pkg and the line_rasterizer_alpha_blend RTL.
module tb_top;
    import lrab_pkg::*;

    typedef struct packed {
        t_req               kind;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [7:0]         sb;
        logic [7:0]         sg;
        logic [7:0]         sr;
        logic [7:0]         sa;
        logic [7:0]         db;
        logic [7:0]         dg;
        logic [7:0]         dr;
    } draw_req_t;

    typedef struct packed {
        logic signed [15:0] wx;
        logic signed [15:0] wy;
        logic               we;
        logic [7:0]         b;
        logic [7:0]         g;
        logic [7:0]         r;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic               done;
    } pixel_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = 1'b0;
    logic signed [15:0] i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic [7:0]  i_src_blue = '0, i_src_green = '0, i_src_red = '0, i_src_alpha = '0;
    logic [7:0]  i_dst_blue = '0, i_dst_green = '0, i_dst_red = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [15:0] o_write_x, o_write_y, o_next_x, o_next_y;
    logic        o_write_enable, o_line_done;
    logic [7:0]  o_out_blue, o_out_green, o_out_red;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    line_rasterizer_alpha_blend dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: target size, pending point, endpoint and Bresenham terms.
    logic [13:0]        tgt_w = RESET_WIDTH;
    logic [13:0]        tgt_h = RESET_HEIGHT;
    logic signed [15:0] pen_x = '0, pen_y = '0, goal_x = '0, goal_y = '0;
    logic [16:0]        dx_mag = '0;
    logic signed [17:0] dy_neg = '0;
    logic signed [18:0] err = '0;
    logic               x_back = 1'b0, y_back = 1'b0;
    logic [31:0]        line_rgba = '0;
    logic               drawing = 1'b0;

    draw_req_t draw_req_q[$];
    pixel_t    pixel_due_q[$];

    int  send_gap_pct = 0;
    int  recv_stall_pct = 0;
    bit  req_sent = 1'b0;
    logic [31:0] drv_cycle = '0;
    int  reqs_taken = 0, lines_loaded = 0, pixels_written = 0, pixels_checked = 0;
    int  fail_cnt = 0;

    function automatic logic [7:0] mix_channel(logic [7:0] c, logic [7:0] d, logic [7:0] a);
        int v;
        v = int'(c) * int'(a) + int'(d) * (int'(CHAN_MAX) - int'(a));
        return 8'(v / int'(CHAN_MAX));
    endfunction

    function automatic pixel_t walk_and_blend(draw_req_t rq);
        pixel_t px;
        int     ddx, ddy, e2;
        px = '0;
        if (rq.kind == REQ_LOAD) begin
            ddx       = int'(rq.ex) - int'(rq.sx);
            ddy       = int'(rq.ey) - int'(rq.sy);
            pen_x     = rq.sx;
            pen_y     = rq.sy;
            goal_x    = rq.ex;
            goal_y    = rq.ey;
            dx_mag    = 17'(ddx < 0 ? -ddx : ddx);
            dy_neg    = 18'(ddy < 0 ? ddy : -ddy);
            x_back    = !(rq.sx < rq.ex);
            y_back    = !(rq.sy < rq.ey);
            err       = 19'(int'(dx_mag) + int'(dy_neg));
            line_rgba = {rq.sa, rq.sr, rq.sg, rq.sb};
            drawing   = 1'b1;
            lines_loaded++;
        end else if (!drawing) begin
            px.wx   = pen_x;
            px.wy   = pen_y;
            px.done = 1'b1;
        end else begin
            px.wx = pen_x;
            px.wy = pen_y;
            if (pen_x >= 0 && pen_y >= 0 && int'(pen_x) < int'(tgt_w)
                    && int'(pen_y) < int'(tgt_h) && line_rgba[31:24] != 8'd0) begin
                px.we = 1'b1;
                px.b  = mix_channel(line_rgba[7:0], rq.db, line_rgba[31:24]);
                px.g  = mix_channel(line_rgba[15:8], rq.dg, line_rgba[31:24]);
                px.r  = mix_channel(line_rgba[23:16], rq.dr, line_rgba[31:24]);
            end
            if (pen_x == goal_x && pen_y == goal_y) begin
                drawing = 1'b0;
                px.done = 1'b1;
            end else begin
                e2 = 2 * int'(err);
                if (e2 >= int'(dy_neg)) begin
                    err   = 19'(int'(err) + int'(dy_neg));
                    pen_x = 16'(int'(pen_x) + (x_back ? -1 : 1));
                end
                if (e2 <= int'(dx_mag)) begin
                    err   = 19'(int'(err) + int'(dx_mag));
                    pen_y = 16'(int'(pen_y) + (y_back ? -1 : 1));
                end
            end
        end
        px.nx = pen_x;
        px.ny = pen_y;
        return px;
    endfunction

    function automatic draw_req_t noise_req();
        draw_req_t rq;
        rq.kind = $urandom_range(1) ? REQ_STEP : REQ_LOAD;
        rq.sx = 16'($urandom);
        rq.sy = 16'($urandom);
        rq.ex = 16'($urandom);
        rq.ey = 16'($urandom);
        rq.sb = 8'($urandom);
        rq.sg = 8'($urandom);
        rq.sr = 8'($urandom);
        rq.sa = 8'($urandom);
        rq.db = 8'($urandom);
        rq.dg = 8'($urandom);
        rq.dr = 8'($urandom);
        return rq;
    endfunction

    task automatic push_load(int sx, int sy, int ex, int ey,
                             logic [7:0] b, logic [7:0] g, logic [7:0] r, logic [7:0] a);
        draw_req_t rq;
        rq = noise_req();
        rq.kind = REQ_LOAD;
        rq.sx = 16'(sx);
        rq.sy = 16'(sy);
        rq.ex = 16'(ex);
        rq.ey = 16'(ey);
        rq.sb = b;
        rq.sg = g;
        rq.sr = r;
        rq.sa = a;
        draw_req_q.push_back(rq);
    endtask

    task automatic push_step(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        draw_req_t rq;
        rq = noise_req();
        rq.kind = REQ_STEP;
        rq.db = b;
        rq.dg = g;
        rq.dr = r;
        draw_req_q.push_back(rq);
    endtask

    // A coordinate near the origin or near the far edge of the target along one axis.
    function automatic int near_edge(int lim);
        if ($urandom_range(1) == 0)
            return int'($urandom_range(lim > 40 ? 48 : lim + 8)) - 4;
        return lim - 6 + int'($urandom_range(12));
    endfunction

    // Mostly complete short lines with random colors; some far-apart endpoints that are
    // abandoned after a few points, some cut-off lines and some stray steps.
    task automatic queue_random_lines(int quota);
        int pushed, roll, pick, steps, len, x0, y0, x1, y1, ax, ay;
        logic [7:0] alpha;
        pushed = 0;
        while (pushed < quota) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                push_step(8'($urandom), 8'($urandom), 8'($urandom));
                pushed++;
            end else begin
                pick  = $urandom_range(99);
                alpha = pick < 15 ? 8'd0 : (pick < 30 ? CHAN_MAX : 8'($urandom));
                if (roll < 20) begin
                    x0 = int'($urandom_range(65535)) - 32768;
                    y0 = int'($urandom_range(65535)) - 32768;
                    x1 = int'($urandom_range(65535)) - 32768;
                    y1 = int'($urandom_range(65535)) - 32768;
                    steps = $urandom_range(4);
                end else begin
                    x0 = near_edge(int'(tgt_w));
                    y0 = near_edge(int'(tgt_h));
                    x1 = x0 + int'($urandom_range(24)) - 12;
                    y1 = y0 + ($urandom_range(9) == 0 ? 0 : int'($urandom_range(24)) - 12);
                    ax = x1 > x0 ? x1 - x0 : x0 - x1;
                    ay = y1 > y0 ? y1 - y0 : y0 - y1;
                    len = (ax > ay ? ax : ay) + 1;
                    if (roll < 25)
                        steps = $urandom_range(len - 1);
                    else
                        steps = len + ($urandom_range(4) == 0 ? int'($urandom_range(1, 2)) : 0);
                end
                push_load(x0, y0, x1, y1, 8'($urandom), 8'($urandom), 8'($urandom), alpha);
                repeat (steps) push_step(8'($urandom), 8'($urandom), 8'($urandom));
                pushed += steps + 1;
            end
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [13:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_TARGET_WIDTH)
            tgt_w = val;
        else
            tgt_h = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_target(int w, int h);
        write_reg(CFG_TARGET_WIDTH, 14'(w));
        write_reg(CFG_TARGET_HEIGHT, 14'(h));
    endtask

    task automatic drain();
        while (draw_req_q.size() != 0 || pixel_due_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string tag, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
            fail_cnt++;
        end
    endtask

    // Driver: a new request is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        logic calm;
        calm = drv_cycle[7:0] < 8'd40;
        drv_cycle <= drv_cycle + 1;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_sent) begin
            if (draw_req_q.size() != 0 && (calm || $urandom_range(99) >= send_gap_pct)) begin
                i_in_valid  <= 1'b1;
                i_req_type  <= draw_req_q[0].kind;
                i_start_x   <= draw_req_q[0].sx;
                i_start_y   <= draw_req_q[0].sy;
                i_end_x     <= draw_req_q[0].ex;
                i_end_y     <= draw_req_q[0].ey;
                i_src_blue  <= draw_req_q[0].sb;
                i_src_green <= draw_req_q[0].sg;
                i_src_red   <= draw_req_q[0].sr;
                i_src_alpha <= draw_req_q[0].sa;
                i_dst_blue  <= draw_req_q[0].db;
                i_dst_green <= draw_req_q[0].dg;
                i_dst_red   <= draw_req_q[0].dr;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        req_sent = 1'b0;
        i_out_stall <= !calm && ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: predicts on every accepted request and scores every accepted pixel.
    always @(posedge i_clk) begin
        pixel_t want, got;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pixel_due_q.push_back(walk_and_blend(draw_req_q.pop_front()));
            req_sent = 1'b1;
            reqs_taken++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_write_x, o_write_y, o_write_enable, o_out_blue, o_out_green, o_out_red,
                   o_next_x, o_next_y, o_line_done};
            if (pixel_due_q.size() == 0) begin
                $display("%0t ns: unexpected pixel, expected none, got %p", $time, got);
                fail_cnt++;
            end else begin
                want = pixel_due_q.pop_front();
                check_field("write_x", int'(want.wx), int'(got.wx));
                check_field("write_y", int'(want.wy), int'(got.wy));
                check_field("write_enable", int'(want.we), int'(got.we));
                check_field("out_blue", int'(want.b), int'(got.b));
                check_field("out_green", int'(want.g), int'(got.g));
                check_field("out_red", int'(want.r), int'(got.r));
                check_field("next_x", int'(want.nx), int'(got.nx));
                check_field("next_y", int'(want.ny), int'(got.ny));
                check_field("line_done", int'(want.done), int'(got.done));
                if (want.we)
                    pixels_written++;
                pixels_checked++;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct   = 34;
        recv_stall_pct = 80;
        // Directed part at the reset target size.
        push_step(8'd10, 8'd20, 8'd30);            // step before any line was loaded
        push_load(0, 0, 0, 0, 8'd11, 8'd22, 8'd33, CHAN_MAX);
        push_step(8'd1, 8'd2, 8'd3);               // single-point line, opaque
        push_step(8'd4, 8'd5, 8'd6);               // step after the line finished
        push_load(5, 5, 7, 6, 8'd200, 8'd100, 8'd50, 8'd0);
        repeat (3) push_step(8'd9, 8'd8, 8'd7);    // transparent line writes nothing
        push_load(3, 2, 0, 2, CHAN_MAX, 8'd0, 8'd128, 8'd128);
        repeat (2) push_step(CHAN_MAX, CHAN_MAX, 8'd0);
        // The next load drops the half-drawn line above.
        push_load(-32768, 32767, 32767, -32768, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX);
        repeat (2) push_step(8'd0, 8'd0, 8'd0);
        push_load(1919, 1079, 1920, 1080, 8'd0, 8'd0, 8'd0, 8'd1);
        repeat (2) push_step(CHAN_MAX, CHAN_MAX, CHAN_MAX);
        push_load(2, 0, 0, 3, 8'd90, 8'd160, 8'd230, 8'd77);
        repeat (5) push_step(8'd40, 8'd80, 8'd120);
        drain();

        set_target(40, 30);
        queue_random_lines(140);
        drain();

        send_gap_pct   = 80;
        recv_stall_pct = 34;
        set_target(16383, 16383);
        queue_random_lines(140);
        drain();
        set_target(0, 0);
        queue_random_lines(140);
        drain();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        set_target(1, 1);
        queue_random_lines(140);
        drain();
        set_target(100, 60);
        queue_random_lines(140);
        drain();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d requests: %0d lines loaded, %0d blended pixels written,",
                 reqs_taken, lines_loaded, pixels_written);
        $display("%0d pixels checked over six target sizes and three stall mixes.",
                 pixels_checked);
        if (fail_cnt == 0 && pixel_due_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
